### rtl/core/assert_macros.svh
// assertion macros shared by the call table rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every rising edge outside reset
`define AMOC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define AMOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AMOC_ASSERT(lbl, clk, rst_n, prop, msg)
`define AMOC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/core/amoc_pkg.sv
// types and constants of the at-most-once call table
// no dependencies
`default_nettype none

package amoc_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int KEY_W  = 32;
  localparam int SEQ_W  = 32;
  localparam int VAL_W  = 32;
  localparam int SLOT_W = 7;

  typedef enum logic [1:0] {
    ACT_REQUEST  = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_STALE    = 3'd0,
    ST_ACK      = 3'd1,
    ST_REPLAY   = 3'd2,
    ST_START    = 3'd3,
    ST_FULL     = 3'd4,
    ST_UPDATED  = 3'd5,
    ST_REMOVED  = 3'd6,
    ST_NOTFOUND = 3'd7
  } status_t;

  typedef struct packed {
    logic             valid;
    logic             busy;
    logic [KEY_W-1:0] client;
    logic [SEQ_W-1:0] seq;
    logic [VAL_W-1:0] value;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic scan_issue;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

### rtl/core/amoc_if.sv
// request and result channel interfaces of the call table
// depends on amoc_pkg for field widths
`default_nettype none

interface amoc_in_if import amoc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [KEY_W-1:0]        client_key;
  logic signed [SEQ_W-1:0] sequence_req;
  logic signed [VAL_W-1:0] call_result;

  modport source (output valid, action, client_key, sequence_req, call_result,
                  input ready);
  modport sink (input valid, action, client_key, sequence_req, call_result,
                output ready);
endinterface

interface amoc_out_if import amoc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic signed [VAL_W-1:0] replay_value;
  logic [SLOT_W-1:0]       slot_index;

  modport source (output valid, status, replay_value, slot_index, input ready);
  modport sink (input valid, status, replay_value, slot_index, output ready);
endinterface

`default_nettype wire

### rtl/core/amoc_ctrl.sv
// controller state machine: clearing pass, table scan, decide and commit
// depends on amoc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module amoc_ctrl import amoc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.addr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.addr_last) state_r <= S_DRAIN;
        end
        // last read data lands in this cycle
        S_DRAIN: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd.clear_wr   = (state_r == S_CLEAR);
    cmd.load_in    = (state_r == S_IDLE) && in_valid;
    cmd.scan_issue = (state_r == S_SCAN);
    cmd.commit     = (state_r == S_DECIDE) && sts.out_free;
  end

  `AMOC_ASSERT(a_scan_runs_to_end, clk, rst_n, (state_r == S_SCAN && !sts.addr_last) |=> state_r == S_SCAN, "scan left before last slot")
  `AMOC_ASSERT(a_load_starts_scan, clk, rst_n, cmd.load_in |=> state_r == S_SCAN, "accepted request did not start a scan")
  `AMOC_ASSERT(a_commit_after_drain, clk, rst_n, cmd.commit |-> ($past(state_r) == S_DRAIN || $past(state_r) == S_DECIDE), "commit without a finished scan")

endmodule

`default_nettype wire

### rtl/core/amoc_dp.sv
// datapath: entry memory, scan trackers, decision logic and result register
// depends on amoc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module amoc_dp import amoc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctl_cmd_t                cmd,
  output ctl_sts_t                     sts,
  input  wire logic [1:0]              in_action,
  input  wire logic [KEY_W-1:0]        in_client_key,
  input  wire logic signed [SEQ_W-1:0] in_sequence_req,
  input  wire logic signed [VAL_W-1:0] in_call_result,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic signed [VAL_W-1:0]      out_replay_value,
  output logic [SLOT_W-1:0]            out_slot_index
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];

  logic [IdxW-1:0]         addr_r;
  action_t                 act_r;
  logic [KEY_W-1:0]        key_r;
  logic signed [SEQ_W-1:0] seq_r;
  logic signed [VAL_W-1:0] res_r;

  logic                    rd_vld_r;
  logic [IdxW-1:0]         rd_tag_r;
  entry_t                  rd_data_r;

  logic                    hit_found_r;
  logic [IdxW-1:0]         hit_idx_r;
  entry_t                  hit_ent_r;
  logic                    free_found_r;
  logic [IdxW-1:0]         free_idx_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_replay_r;
  logic [SLOT_W-1:0]       out_slot_r;

  logic                    dec_wr;
  logic [IdxW-1:0]         dec_addr;
  entry_t                  dec_ent;
  status_t                 dec_status;
  logic signed [VAL_W-1:0] dec_replay;
  logic [IdxW-1:0]         dec_slot;
  logic                    seq_lt;
  logic                    seq_eq;

  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  entry_t                  mem_wdata;

  // shared address counter for the clearing pass and the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.load_in) begin
      addr_r <= '0;
    end else if (cmd.clear_wr || cmd.scan_issue) begin
      addr_r <= (addr_r == LastIdx) ? '0 : addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= action_t'(in_action);
      key_r <= in_client_key;
      seq_r <= in_sequence_req;
      res_r <= in_call_result;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_data_r <= mem[addr_r];
      rd_tag_r  <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= cmd.scan_issue;
  end

  // keep the lowest matching slot and the lowest free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load_in) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!hit_found_r && rd_data_r.valid && rd_data_r.client == key_r) hit_found_r <= 1'b1;
      if (!free_found_r && !rd_data_r.valid) free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (!hit_found_r && rd_data_r.valid && rd_data_r.client == key_r) begin
        hit_idx_r <= rd_tag_r;
        hit_ent_r <= rd_data_r;
      end
      if (!free_found_r && !rd_data_r.valid) free_idx_r <= rd_tag_r;
    end
  end

  assign seq_lt = seq_r < $signed(hit_ent_r.seq);
  assign seq_eq = seq_r == $signed(hit_ent_r.seq);

  always_comb begin
    dec_wr     = 1'b0;
    dec_addr   = hit_idx_r;
    dec_ent    = hit_ent_r;
    dec_status = ST_NOTFOUND;
    dec_replay = '0;
    dec_slot   = '0;
    unique case (act_r)
      ACT_REQUEST: begin
        if (hit_found_r) begin
          dec_slot = hit_idx_r;
          if (seq_lt) begin
            dec_status = ST_STALE;
          end else if (seq_eq) begin
            if (hit_ent_r.busy) begin
              dec_status = ST_ACK;
            end else begin
              dec_status = ST_REPLAY;
              dec_replay = hit_ent_r.value;
            end
          end else begin
            dec_wr       = 1'b1;
            dec_ent.seq  = seq_r;
            dec_ent.busy = 1'b1;
            dec_status   = ST_START;
          end
        end else if (free_found_r) begin
          // new client takes the lowest free slot, marked in progress
          dec_wr         = 1'b1;
          dec_addr       = free_idx_r;
          dec_ent.valid  = 1'b1;
          dec_ent.busy   = 1'b1;
          dec_ent.client = key_r;
          dec_ent.seq    = seq_r;
          dec_ent.value  = '0;
          dec_status     = ST_START;
          dec_slot       = free_idx_r;
        end else begin
          dec_status = ST_FULL;
        end
      end
      ACT_COMPLETE: begin
        if (hit_found_r) begin
          dec_wr        = 1'b1;
          dec_ent.busy  = 1'b0;
          dec_ent.seq   = seq_r;
          dec_ent.value = res_r;
          dec_status    = ST_UPDATED;
          dec_slot      = hit_idx_r;
        end
      end
      ACT_REMOVE: begin
        if (hit_found_r) begin
          dec_wr        = 1'b1;
          dec_ent.valid = 1'b0;
          dec_status    = ST_REMOVED;
          dec_slot      = hit_idx_r;
        end
      end
      ACT_NONE: begin
        dec_status = ST_NOTFOUND;
      end
    endcase
  end

  always_comb begin
    mem_we    = cmd.clear_wr || (cmd.commit && dec_wr);
    mem_waddr = cmd.clear_wr ? addr_r : dec_addr;
    mem_wdata = cmd.clear_wr ? entry_t'('0) : dec_ent;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= dec_status;
      out_replay_r <= dec_replay;
      out_slot_r   <= SLOT_W'(dec_slot);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_replay_value = out_replay_r;
  assign out_slot_index   = out_slot_r;

  assign sts.addr_last = (addr_r == LastIdx);
  assign sts.out_free  = !out_valid_r || out_ready;

  `AMOC_ASSERT(a_commit_needs_room, clk, rst_n, cmd.commit |-> (!out_valid_r || out_ready), "result overwritten before it was taken")
  `AMOC_ASSERT(a_replay_only_on_replay, clk, rst_n, (out_valid_r && out_status_r != ST_REPLAY) |-> out_replay_r == '0, "replay value set without replay status")
  `AMOC_ASSERT(a_first_hit_kept, clk, rst_n, (hit_found_r && rd_vld_r) |=> $stable(hit_idx_r), "a later slot replaced the first match")

endmodule

`default_nettype wire

### rtl/core/at_most_once_call_table.sv
// at-most-once call table: one request in, one result out
// after acceptance the scan reads one entry a cycle through the single memory read port, then
// a drain and a decide state follow; decide waits until the result register is free
// a new request is taken only once the last one is decided; the result register lets the
// next request start while a result waits
// reset: synchronous, active low; a clearing pass over every entry follows, ready low
`default_nettype none

module at_most_once_call_table import amoc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  amoc_in_if.sink     in_chan,
  amoc_out_if.source  out_chan
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  amoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  amoc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_chan.action),
    .in_client_key    (in_chan.client_key),
    .in_sequence_req  (in_chan.sequence_req),
    .in_call_result   (in_chan.call_result),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_status       (out_chan.status),
    .out_replay_value (out_chan.replay_value),
    .out_slot_index   (out_chan.slot_index)
  );

endmodule

`default_nettype wire

### verif/tb_at_most_once_call_table.sv
// testbench for at_most_once_call_table: directed table, a fill of the table, then random request traffic
// checked against a behavioral predictor of the client table
// depends on amoc_pkg and the amoc_in_if / amoc_out_if interfaces
`default_nettype none

module tb_at_most_once_call_table;
  timeunit 1ns;
  timeprecision 1ps;
  import amoc_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int ITEM_TARGET   = 1500;
  localparam int PHASE_SPLIT   = 800;
  localparam int STALL_LIMIT   = 5000;
  localparam int POOL_SIZE     = 256;
  localparam logic signed [SEQ_W-1:0] SEQ_MIN = 32'sh8000_0000;
  localparam logic signed [SEQ_W-1:0] SEQ_MAX = 32'sh7fff_ffff;

  localparam logic [KEY_W-1:0] KEY_LO  = 32'h0000_0000;
  localparam logic [KEY_W-1:0] KEY_HI  = 32'hffff_ffff;
  localparam logic [KEY_W-1:0] KEY_MID = 32'h5a5a_5a5a;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  replay;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  typedef struct packed {
    action_t          act;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
    logic [VAL_W-1:0] res;
    logic             spelled;  // answer typed in below instead of predicted
    answer_t          want;
  } call_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam call_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ACT_COMPLETE, KEY_LO,  32'h0,         32'h0,         1'b1, '{ST_NOTFOUND, 32'h0, 7'd0}},
    '{ACT_REMOVE,   KEY_HI,  32'h0,         32'h0,         1'b1, '{ST_NOTFOUND, 32'h0, 7'd0}},
    '{ACT_NONE,     KEY_LO,  32'h0,         32'h0,         1'b1, '{ST_NOTFOUND, 32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'h0,         32'h0,         1'b1, '{ST_START,    32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_HI,  32'h8000_0000, 32'h0,         1'b1, '{ST_START,    32'h0, 7'd1}},
    '{ACT_REQUEST,  KEY_LO,  32'h0,         32'h0,         1'b1, '{ST_ACK,      32'h0, 7'd0}},
    '{ACT_COMPLETE, KEY_LO,  32'h0,         32'h7fff_ffff, 1'b1, '{ST_UPDATED,  32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'h0,         32'h0,         1'b1,
      '{ST_REPLAY, 32'h7fff_ffff, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'hffff_ffff, 32'h0,         1'b1, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'h7fff_ffff, 32'h0,         1'b1, '{ST_START,    32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'h7fff_ffff, 32'h0,         1'b1, '{ST_ACK,      32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_HI,  32'h8000_0000, 32'h0,         1'b1, '{ST_ACK,      32'h0, 7'd1}},
    '{ACT_COMPLETE, KEY_HI,  32'h5,         32'h8000_0000, 1'b1, '{ST_UPDATED,  32'h0, 7'd1}},
    '{ACT_REQUEST,  KEY_HI,  32'h5,         32'h0,         1'b1,
      '{ST_REPLAY, 32'h8000_0000, 7'd1}},
    '{ACT_REQUEST,  KEY_HI,  32'h4,         32'h0,         1'b0, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_NONE,     KEY_HI,  32'h6,         32'h1,         1'b1, '{ST_NOTFOUND, 32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_HI,  32'h5,         32'h0,         1'b0, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_REMOVE,   KEY_LO,  32'h0,         32'h0,         1'b1, '{ST_REMOVED,  32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_MID, 32'hc000_0000, 32'h0,         1'b0, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'h3,         32'h0,         1'b0, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_COMPLETE, KEY_LO,  32'h1,         32'hffff_ffff, 1'b0, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_REQUEST,  KEY_LO,  32'h1,         32'h0,         1'b0, '{ST_STALE,    32'h0, 7'd0}},
    '{ACT_REMOVE,   KEY_HI,  32'h0,         32'h0,         1'b1, '{ST_REMOVED,  32'h0, 7'd1}},
    '{ACT_REMOVE,   KEY_HI,  32'h0,         32'h0,         1'b1, '{ST_NOTFOUND, 32'h0, 7'd0}},
    '{ACT_COMPLETE, KEY_HI,  32'h9,         32'h2,         1'b1, '{ST_NOTFOUND, 32'h0, 7'd0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  amoc_in_if  in_chan ();
  amoc_out_if out_chan ();

  at_most_once_call_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted client table
  logic                    tbl_valid  [TABLE_ENTRIES];
  logic                    tbl_busy   [TABLE_ENTRIES];
  logic [KEY_W-1:0]        tbl_client [TABLE_ENTRIES];
  logic signed [SEQ_W-1:0] tbl_seq    [TABLE_ENTRIES];
  logic [VAL_W-1:0]        tbl_value  [TABLE_ENTRIES];

  answer_t          pending_answers [$];
  logic [KEY_W-1:0] client_pool [POOL_SIZE];
  int               bad = 0;
  int               idle_cycles = 0;
  bit               calm = 1'b0;
  int               calm_left = 40;

  function automatic int locate_client(logic [KEY_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_client[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int first_vacant();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tbl_valid[i]) return i;
    end
    return -1;
  endfunction

  function automatic answer_t predict_call(call_row_t row);
    answer_t a;
    int hit;
    int vac;
    a = '{ST_NOTFOUND, '0, '0};
    hit = locate_client(row.key);
    case (row.act)
      ACT_REQUEST: begin
        if (hit >= 0) begin
          a.slot = hit[SLOT_W-1:0];
          if ($signed(row.seq) < tbl_seq[hit]) begin
            a.status = ST_STALE;
          end else if ($signed(row.seq) == tbl_seq[hit]) begin
            if (tbl_busy[hit]) begin
              a.status = ST_ACK;
            end else begin
              a.status = ST_REPLAY;
              a.replay = tbl_value[hit];
            end
          end else begin
            tbl_seq[hit]  = row.seq;
            tbl_busy[hit] = 1'b1;
            a.status = ST_START;
          end
        end else begin
          vac = first_vacant();
          if (vac >= 0) begin
            tbl_valid[vac]  = 1'b1;
            tbl_busy[vac]   = 1'b1;
            tbl_client[vac] = row.key;
            tbl_seq[vac]    = row.seq;
            tbl_value[vac]  = '0;
            a.status = ST_START;
            a.slot   = vac[SLOT_W-1:0];
          end else begin
            a.status = ST_FULL;
          end
        end
      end
      ACT_COMPLETE: begin
        if (hit >= 0) begin
          tbl_busy[hit]  = 1'b0;
          tbl_seq[hit]   = row.seq;
          tbl_value[hit] = row.res;
          a.status = ST_UPDATED;
          a.slot   = hit[SLOT_W-1:0];
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          a.status = ST_REMOVED;
          a.slot   = hit[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // mostly short gaps, now and then one long enough to span a whole scan
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // sequence numbers follow the stored one so repeats, retries and new calls all show up
  function automatic call_row_t make_call(int pool_n, int rm_w);
    call_row_t row;
    int pick;
    int hit;
    int k;
    logic signed [SEQ_W-1:0] cur;
    row  = '0;
    pick = $urandom_range(0, 99);
    if (pick < rm_w) row.act = ACT_REMOVE;
    else if (pick < rm_w + 3) row.act = ACT_NONE;
    else if (pick < rm_w + 30) row.act = ACT_COMPLETE;
    else row.act = ACT_REQUEST;
    row.key = ($urandom_range(0, 19) == 0) ? $urandom : client_pool[$urandom_range(0, pool_n - 1)];
    row.seq = edge_word();
    row.res = edge_word();
    hit = locate_client(row.key);
    if (hit >= 0 && row.act != ACT_REMOVE) begin
      cur  = tbl_seq[hit];
      k    = $urandom_range(1, 3);
      pick = $urandom_range(0, 99);
      if (row.act == ACT_COMPLETE) begin
        if (pick < 75) row.seq = cur;
      end else if (pick < 30) begin
        row.seq = cur;
      end else if (pick < 45) begin
        if (cur > SEQ_MIN + 3) row.seq = cur - k;
      end else if (pick < 85) begin
        row.seq = (cur < SEQ_MAX - 3) ? cur + k : cur;
      end
    end
    return row;
  endfunction

  task automatic send_call(input call_row_t row);
    int unsigned gap;
    answer_t guess;
    gap = calm ? 0 : pick_gap();
    if (calm_left == 0) begin
      calm = !calm;
      calm_left = $urandom_range(30, 120);
    end else begin
      calm_left--;
    end
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.action       <= row.act;
    in_chan.client_key   <= row.key;
    in_chan.sequence_req <= row.seq;
    in_chan.call_result  <= row.res;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    guess = predict_call(row);
    pending_answers.push_back(row.spelled ? row.want : guess);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int unsigned hold;
    out_chan.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 6) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_answers.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("unexpected result: status %0d replay %h slot %0d",
                   out_chan.status, out_chan.replay_value, out_chan.slot_index);
      end else begin
        want = pending_answers.pop_front();
        if (out_chan.status !== want.status || out_chan.replay_value !== want.replay ||
            out_chan.slot_index !== want.slot) begin
          bad++;
          if (bad <= 10)
            $display("mismatch: expected status %0d replay %h slot %0d, got %0d %h %0d",
                     want.status, want.replay, want.slot,
                     out_chan.status, out_chan.replay_value, out_chan.slot_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    call_row_t row;
    int sent;
    int fresh;
    int pool_n;
    int rm_w;
    bit split_done;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.action       = ACT_NONE;
    in_chan.client_key   = '0;
    in_chan.sequence_req = '0;
    in_chan.call_result  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_busy[i]   = 1'b0;
      tbl_client[i] = '0;
      tbl_seq[i]    = '0;
      tbl_value[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) client_pool[i] = $urandom;
    sent = 0;
    fresh = 0;
    split_done = 1'b0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_call(DIRECTED[i]);
    drain_results();

    // fill every slot with new clients, then knock on the full table
    while (first_vacant() >= 0 && fresh < POOL_SIZE - 3) begin
      row = '{ACT_REQUEST, client_pool[fresh], edge_word(), $urandom, 1'b0, '0};
      send_call(row);
      fresh++;
      sent++;
    end
    repeat (3) begin
      row = '{ACT_REQUEST, client_pool[fresh], edge_word(), $urandom, 1'b0, '0};
      send_call(row);
      fresh++;
      sent++;
    end
    drain_results();

    while (sent < ITEM_TARGET) begin
      if (sent < PHASE_SPLIT) begin
        pool_n = 200;
        rm_w   = 4;
      end else begin
        pool_n = 48;
        rm_w   = 18;
        if (!split_done) begin
          drain_results();
          split_done = 1'b1;
        end
      end
      if ($urandom_range(0, 99) == 0) drain_results();
      row = make_call(pool_n, rm_w);
      send_call(row);
      if (row.act != ACT_NONE) sent++;
    end

    drain_results();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (bad == 0 && pending_answers.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
